### design/unix_seconds_to_date_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seconds-to-date converter
// Shared property shapes, all sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_DATE_UNIT_MACROS_SVH
`define UNIX_SECONDS_TO_DATE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/usd_pkg.sv
// ----------------------------------------------------------------------------
// Seconds-to-date package
// Field types, division constants and calendar helpers for the converter.
// ----------------------------------------------------------------------------
package usd_pkg;

    // Field types of the input and result words.
    typedef logic [31:0] stamp_t;
    typedef logic [11:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  mday_t;
    typedef logic [4:0]  hour_t;
    typedef logic [5:0]  minsec_t;
    typedef logic [2:0]  wday_t;

    // Internal types.
    typedef logic [15:0] dcount_t;
    typedef logic [8:0]  doy_t;
    typedef logic [16:0] sod_t;

    // Marker for an unsynchronized clock.
    localparam stamp_t INVALID_STAMP = 32'hFFFF_FFFF;

    // Seconds to days: 86400 = 128 * 675. Reciprocal of 675 rounded down,
    // so the quotient estimate is exact or one low.
    localparam int          SEC_SHIFT       = 7;
    localparam logic [9:0]  DAY_ODD         = 10'd675;
    localparam logic [31:0] DAY_RECIP       = 32'd3257812230;
    localparam int          DAY_RECIP_SHIFT = 41;

    // Hour: sod / 3600 = (sod >> 4) / 225, rounded-up reciprocal, exact here.
    localparam logic [12:0] HOUR_RECIP       = 13'd4661;
    localparam int          HOUR_RECIP_SHIFT = 20;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;

    // Minute: rem / 60 = (rem >> 2) / 15, rounded-up reciprocal, exact here.
    localparam logic [10:0] MIN_RECIP       = 11'd1093;
    localparam int          MIN_RECIP_SHIFT = 14;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

    // Weekday: (days + 4) mod 7; 1970-01-01 was a Thursday.
    localparam logic [2:0]  BASE_WEEKDAY     = 3'd4;
    localparam logic [16:0] WEEK_RECIP       = 17'd74899;
    localparam int          WEEK_RECIP_SHIFT = 19;
    localparam logic [2:0]  DAYS_PER_WEEK    = 3'd7;

    // Year: count days from 1968-01-01 in four-year cycles of 1461 days.
    // Dates from 2100-03-01 on get one extra day so that the missing
    // leap day of 2100 is stepped over.
    localparam year_t       CYCLE_BASE_YEAR   = 12'd1968;
    localparam dcount_t     DAYS_1968_TO_1970 = 16'd731;
    localparam dcount_t     MAR_2100_DAY      = 16'd47541;
    localparam logic [15:0] CYCLE_RECIP       = 16'd45934;
    localparam int          CYCLE_RECIP_SHIFT = 26;
    localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;

    // Start of the second, third and fourth year within a four-year group.
    localparam logic [10:0] CYC_YEAR1 = 11'd366;
    localparam logic [10:0] CYC_YEAR2 = 11'd731;
    localparam logic [10:0] CYC_YEAR3 = 11'd1096;

    // Day of year on which a month starts, counted from zero.
    function automatic doy_t month_start(month_t m, logic leap);
        doy_t base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd3))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Month that holds a given day of year; the compares are independent.
    function automatic month_t month_of(doy_t doy, logic leap);
        month_t m;
        m = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (doy >= month_start(4'(k), leap))
            begin
                m = m + 4'd1;
            end
        end
        return m;
    endfunction

endpackage

### design/unix_seconds_to_date_unit.sv
// ----------------------------------------------------------------------------
// Seconds-to-date converter
// Throughput: one word per cycle while no stall backs up from the output; eight stages.
// A stall from the output backs up only through full stages; a bubble is squeezed out.
// Reset clears all valid bits; the payload registers are not reset.
// ----------------------------------------------------------------------------
module unix_seconds_to_date_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  usd_pkg::stamp_t epoch_seconds,
    output logic            out_valid,
    input  logic            out_stall,
    output usd_pkg::year_t  year,
    output usd_pkg::month_t month,
    output usd_pkg::mday_t  day,
    output usd_pkg::hour_t  hour,
    output usd_pkg::minsec_t minute,
    output usd_pkg::minsec_t second,
    output usd_pkg::wday_t  weekday
);
    import usd_pkg::*;

    // Pipeline control.
    logic [8:1] vld_reg;
    logic [8:1] vld_next;
    logic [8:1] stage_load;

    // Stage 1: day quotient product.
    logic [56:0] s1_prod_reg, s1_prod_next;
    logic [24:0] s1_x_reg;
    logic [6:0]  s1_lo_reg;
    logic        s1_inv_reg;

    // Stage 2: quotient estimate and remainder.
    dcount_t     s2_q_reg, s2_q_next;
    logic [10:0] s2_rem_reg, s2_rem_next;
    logic [6:0]  s2_lo_reg;
    logic        s2_inv_reg;
    logic [25:0] s2_qmul;
    logic [24:0] s2_diff;

    // Stage 3: corrected day count and second of day.
    dcount_t     s3_days_reg, s3_days_next;
    sod_t        s3_sod_reg, s3_sod_next;
    logic        s3_inv_reg;
    logic [10:0] s3_rem_fix;

    // Stage 4: products for hour, weekday and year.
    logic [25:0] s4_ph_reg, s4_ph_next;
    logic [32:0] s4_pw_reg, s4_pw_next;
    logic [31:0] s4_py_reg, s4_py_next;
    dcount_t     s4_dw_reg, s4_dw_next;
    dcount_t     s4_dc_reg, s4_dc_next;
    sod_t        s4_sod_reg;
    logic        s4_inv_reg;

    // Stage 5: hour, weekday, cycle and day within cycle.
    hour_t       s5_hour_reg, s5_hour_next;
    logic [11:0] s5_remh_reg, s5_remh_next;
    wday_t       s5_wd_reg, s5_wd_next;
    logic [5:0]  s5_yq_reg, s5_yq_next;
    logic [10:0] s5_yrem_reg, s5_yrem_next;
    logic        s5_inv_reg;
    logic [16:0] s5_hmul;
    logic [16:0] s5_hdiff;
    logic [15:0] s5_wmul;
    logic [15:0] s5_wdiff;
    logic [15:0] s5_ymul;
    logic [15:0] s5_ydiff;

    // Stage 6: minute product, year and day of year.
    logic [19:0] s6_pm_reg, s6_pm_next;
    year_t       s6_year_reg, s6_year_next;
    doy_t        s6_doy_reg, s6_doy_next;
    logic        s6_leap_reg, s6_leap_next;
    logic [1:0]  s6_yr;
    logic [10:0] s6_ydoy;
    logic [11:0] s6_remh_reg;
    hour_t       s6_hour_reg;
    wday_t       s6_wd_reg;
    logic        s6_inv_reg;

    // Stage 7: minute, second and month.
    minsec_t     s7_min_reg, s7_min_next;
    minsec_t     s7_sec_reg, s7_sec_next;
    month_t      s7_mon_reg, s7_mon_next;
    logic [11:0] s7_mmul;
    logic [11:0] s7_mdiff;
    year_t       s7_year_reg;
    doy_t        s7_doy_reg;
    logic        s7_leap_reg;
    hour_t       s7_hour_reg;
    wday_t       s7_wd_reg;
    logic        s7_inv_reg;

    // Stage 8: output word.
    year_t       out_year_reg, out_year_next;
    month_t      out_mon_reg, out_mon_next;
    mday_t       out_day_reg, out_day_next;
    hour_t       out_hour_reg, out_hour_next;
    minsec_t     out_min_reg, out_min_next;
    minsec_t     out_sec_reg, out_sec_next;
    wday_t       out_wd_reg, out_wd_next;
    doy_t        s8_mday0;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        stage_load[8] = !vld_reg[8] || !out_stall;
        for (int k = 7; k >= 1; k--)
        begin
            stage_load[k] = !vld_reg[k] || stage_load[k + 1];
        end
    end

    assign vld_next = {vld_reg[7:1], in_valid};
    assign in_stall = !stage_load[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= 8; k++)
            begin
                if (stage_load[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Stage 1: multiply the seconds over 128 by the reciprocal of 675.
    assign s1_prod_next = 57'(epoch_seconds[31:SEC_SHIFT]) * 57'(DAY_RECIP);

    // Stage 2: take the estimate and form the remainder against it.
    always_comb
    begin
        s2_q_next   = s1_prod_reg[56:DAY_RECIP_SHIFT];
        s2_qmul     = 26'(s2_q_next) * 26'(DAY_ODD);
        s2_diff     = s1_x_reg - s2_qmul[24:0];
        s2_rem_next = s2_diff[10:0];
    end

    // Stage 3: fix an estimate that came out one low.
    always_comb
    begin
        if (s2_rem_reg >= 11'(DAY_ODD))
        begin
            s3_days_next = s2_q_reg + 16'd1;
            s3_rem_fix   = s2_rem_reg - 11'(DAY_ODD);
        end
        else
        begin
            s3_days_next = s2_q_reg;
            s3_rem_fix   = s2_rem_reg;
        end
        s3_sod_next = {s3_rem_fix[9:0], s2_lo_reg};
    end

    // Stage 4: shifted day counts and the reciprocal products.
    always_comb
    begin
        s4_dw_next = s3_days_reg + 16'(BASE_WEEKDAY);
        s4_dc_next = s3_days_reg + DAYS_1968_TO_1970
                   + 16'(s3_days_reg >= MAR_2100_DAY);
        s4_pw_next = 33'(s4_dw_next) * 33'(WEEK_RECIP);
        s4_py_next = 32'(s4_dc_next) * 32'(CYCLE_RECIP);
        s4_ph_next = 26'(s3_sod_reg[16:4]) * 26'(HOUR_RECIP);
    end

    // Stage 5: quotients and their remainders.
    always_comb
    begin
        s5_hour_next = s4_ph_reg[24:HOUR_RECIP_SHIFT];
        s5_hmul      = 17'(s5_hour_next) * 17'(SECS_PER_HOUR);
        s5_hdiff     = s4_sod_reg - s5_hmul;
        s5_remh_next = s5_hdiff[11:0];

        s5_wmul    = 16'(s4_pw_reg[31:WEEK_RECIP_SHIFT]) * 16'(DAYS_PER_WEEK);
        s5_wdiff   = s4_dw_reg - s5_wmul;
        s5_wd_next = s5_wdiff[2:0];

        s5_yq_next   = s4_py_reg[31:CYCLE_RECIP_SHIFT];
        s5_ymul      = 16'(s5_yq_next) * 16'(DAYS_PER_CYCLE);
        s5_ydiff     = s4_dc_reg - s5_ymul;
        s5_yrem_next = s5_ydiff[10:0];
    end

    // Stage 6: minute product and the year within the four-year cycle.
    always_comb
    begin
        s6_pm_next = 20'(s5_remh_reg[11:2]) * 20'(MIN_RECIP);
        if (s5_yrem_reg < CYC_YEAR1)
        begin
            s6_yr   = 2'd0;
            s6_ydoy = s5_yrem_reg;
        end
        else if (s5_yrem_reg < CYC_YEAR2)
        begin
            s6_yr   = 2'd1;
            s6_ydoy = s5_yrem_reg - CYC_YEAR1;
        end
        else if (s5_yrem_reg < CYC_YEAR3)
        begin
            s6_yr   = 2'd2;
            s6_ydoy = s5_yrem_reg - CYC_YEAR2;
        end
        else
        begin
            s6_yr   = 2'd3;
            s6_ydoy = s5_yrem_reg - CYC_YEAR3;
        end
        s6_doy_next  = s6_ydoy[8:0];
        s6_leap_next = (s6_yr == 2'd0);
        s6_year_next = CYCLE_BASE_YEAR + 12'({s5_yq_reg, 2'b00}) + 12'(s6_yr);
    end

    // Stage 7: minute, second and month.
    always_comb
    begin
        s7_min_next = s6_pm_reg[19:MIN_RECIP_SHIFT];
        s7_mmul     = 12'(s7_min_next) * 12'(SECS_PER_MIN);
        s7_mdiff    = s6_remh_reg - s7_mmul;
        s7_sec_next = s7_mdiff[5:0];
        s7_mon_next = month_of(s6_doy_reg, s6_leap_reg);
    end

    // Stage 8: day of month; the invalid marker clears the whole word.
    always_comb
    begin
        s8_mday0 = s7_doy_reg - month_start(s7_mon_reg, s7_leap_reg);
        if (s7_inv_reg)
        begin
            out_year_next = '0;
            out_mon_next  = '0;
            out_day_next  = '0;
            out_hour_next = '0;
            out_min_next  = '0;
            out_sec_next  = '0;
            out_wd_next   = '0;
        end
        else
        begin
            out_year_next = s7_year_reg;
            out_mon_next  = s7_mon_reg;
            out_day_next  = s8_mday0[4:0] + 5'd1;
            out_hour_next = s7_hour_reg;
            out_min_next  = s7_min_reg;
            out_sec_next  = s7_sec_reg;
            out_wd_next   = s7_wd_reg;
        end
    end

    // Payload registers, each stage loading with its valid bit.
    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_x_reg    <= epoch_seconds[31:SEC_SHIFT];
            s1_lo_reg   <= epoch_seconds[SEC_SHIFT-1:0];
            s1_inv_reg  <= (epoch_seconds == INVALID_STAMP);
        end
        if (stage_load[2])
        begin
            s2_q_reg   <= s2_q_next;
            s2_rem_reg <= s2_rem_next;
            s2_lo_reg  <= s1_lo_reg;
            s2_inv_reg <= s1_inv_reg;
        end
        if (stage_load[3])
        begin
            s3_days_reg <= s3_days_next;
            s3_sod_reg  <= s3_sod_next;
            s3_inv_reg  <= s2_inv_reg;
        end
        if (stage_load[4])
        begin
            s4_ph_reg  <= s4_ph_next;
            s4_pw_reg  <= s4_pw_next;
            s4_py_reg  <= s4_py_next;
            s4_dw_reg  <= s4_dw_next;
            s4_dc_reg  <= s4_dc_next;
            s4_sod_reg <= s3_sod_reg;
            s4_inv_reg <= s3_inv_reg;
        end
        if (stage_load[5])
        begin
            s5_hour_reg <= s5_hour_next;
            s5_remh_reg <= s5_remh_next;
            s5_wd_reg   <= s5_wd_next;
            s5_yq_reg   <= s5_yq_next;
            s5_yrem_reg <= s5_yrem_next;
            s5_inv_reg  <= s4_inv_reg;
        end
        if (stage_load[6])
        begin
            s6_pm_reg   <= s6_pm_next;
            s6_year_reg <= s6_year_next;
            s6_doy_reg  <= s6_doy_next;
            s6_leap_reg <= s6_leap_next;
            s6_remh_reg <= s5_remh_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_wd_reg   <= s5_wd_reg;
            s6_inv_reg  <= s5_inv_reg;
        end
        if (stage_load[7])
        begin
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= s7_sec_next;
            s7_mon_reg  <= s7_mon_next;
            s7_year_reg <= s6_year_reg;
            s7_doy_reg  <= s6_doy_reg;
            s7_leap_reg <= s6_leap_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_wd_reg   <= s6_wd_reg;
            s7_inv_reg  <= s6_inv_reg;
        end
        if (stage_load[8])
        begin
            out_year_reg <= out_year_next;
            out_mon_reg  <= out_mon_next;
            out_day_reg  <= out_day_next;
            out_hour_reg <= out_hour_next;
            out_min_reg  <= out_min_next;
            out_sec_reg  <= out_sec_next;
            out_wd_reg   <= out_wd_next;
        end
    end

    // Result word.
    assign out_valid = vld_reg[8];
    assign year      = out_year_reg;
    assign month     = out_mon_reg;
    assign day       = out_day_reg;
    assign hour      = out_hour_reg;
    assign minute    = out_min_reg;
    assign second    = out_sec_reg;
    assign weekday   = out_wd_reg;

endmodule

### design/usd_checker.sv
// ----------------------------------------------------------------------------
// Seconds-to-date port checker
// Watches the converter's ports for output range, marker and flow errors.
// ----------------------------------------------------------------------------
`include "unix_seconds_to_date_unit_macros.svh"

module usd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday
);
    import usd_pkg::*;

    logic        held_word;
    logic [20:0] date_bits;
    logic        marker_word;
    logic        rest_zero;
    logic        date_ok;
    logic        time_ok;

    // Terms shared by the properties below.
    assign held_word   = out_valid && out_stall;
    assign date_bits   = {year, month, day};
    assign marker_word = out_valid && (year == 12'd0);
    assign rest_zero   = (month == 4'd0) && (day == 5'd0) && (hour == 5'd0)
                       && (minute == 6'd0) && (second == 6'd0) && (weekday == 3'd0);
    assign date_ok     = (year >= 12'd1970) && (month >= 4'd1) && (month <= 4'd12)
                       && (day >= 5'd1) && (day <= 5'd31);
    assign time_ok     = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
                       && (weekday <= 3'd6);

    // A held word keeps its date.
    `USD_ASSERT_NEXT(a_hold, held_word, out_valid && $stable(date_bits), "stalled word changed")

    // A zero year only comes from the invalid marker, which clears every field.
    `USD_ASSERT_NOW(a_marker, marker_word, rest_zero, "invalid marker word not all zero")

    // A real date lies in the calendar.
    `USD_ASSERT_NOW(a_date, out_valid && (year != 12'd0), date_ok, "date field out of range")

    // Time of day and weekday stay in range.
    `USD_ASSERT_NOW(a_time, out_valid, time_ok, "time field out of range")

    // The input side only backs up when the output side holds a word.
    `USD_ASSERT_NOW(a_backup, in_stall, held_word, "input stalled with output free")

endmodule

bind unix_seconds_to_date_unit usd_checker u_usd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .weekday   (weekday)
);

### tb/unix_seconds_to_date_checker.sv
// ----------------------------------------------------------------------------
// Seconds-to-date checker
// Watches both channels of the converter. Each accepted input word gets its
// expected calendar date and time of day, worked out by a behavioral
// conversion; each accepted result word is compared with the oldest one.
// ----------------------------------------------------------------------------
module unix_seconds_to_date_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  usd_pkg::stamp_t  epoch_seconds,
    input  logic             out_valid,
    input  logic             out_stall,
    input  usd_pkg::year_t   year,
    input  usd_pkg::month_t  month,
    input  usd_pkg::mday_t   day,
    input  usd_pkg::hour_t   hour,
    input  usd_pkg::minsec_t minute,
    input  usd_pkg::minsec_t second,
    input  usd_pkg::wday_t   weekday,
    output int               date_mismatches,
    output int               dates_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import usd_pkg::*;

    localparam int unsigned SECS_IN_DAY  = 86400;
    localparam int unsigned SECS_IN_HOUR = 3600;
    localparam int unsigned SECS_IN_MIN  = 60;
    localparam int unsigned EPOCH_YEAR   = 1970;
    localparam int unsigned EPOCH_WDAY   = 4;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        stamp_t  stamp;
        year_t   year;
        month_t  month;
        mday_t   mday;
        hour_t   hour;
        minsec_t minute;
        minsec_t second;
        wday_t   weekday;
    } date_t;

    date_t pending_dates[$];

    initial
    begin
        date_mismatches = 0;
        dates_awaited   = 0;
    end

    // Full Gregorian rule: every fourth year, centuries only every fourth.
    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Calendar date and time of day for one count of epoch seconds.
    function automatic date_t stamp_to_date(stamp_t t);
        date_t       d;
        int unsigned days;
        int unsigned rem;
        int unsigned y;
        int unsigned m;
        int unsigned mlen;
        int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        d       = '0;
        d.stamp = t;
        if (t == INVALID_STAMP)
        begin
            return d;
        end
        days      = t / SECS_IN_DAY;
        rem       = t % SECS_IN_DAY;
        d.hour    = hour_t'(rem / SECS_IN_HOUR);
        rem       = rem % SECS_IN_HOUR;
        d.minute  = minsec_t'(rem / SECS_IN_MIN);
        d.second  = minsec_t'(rem % SECS_IN_MIN);
        d.weekday = wday_t'((days + EPOCH_WDAY) % 7);

        // Walk forward whole years, then whole months.
        y = EPOCH_YEAR;
        while (days >= (leap_year(y) ? 366 : 365))
        begin
            days = days - (leap_year(y) ? 366 : 365);
            y++;
        end
        m = 1;
        mlen = month_days[0];
        while (m < 12 && days >= mlen)
        begin
            days = days - mlen;
            m++;
            mlen = (m == 2 && leap_year(y)) ? 29 : month_days[m - 1];
        end
        d.year  = year_t'(y);
        d.month = month_t'(m);
        d.mday  = mday_t'(days + 1);
        return d;
    endfunction

    // Predict on accepted input words, compare on accepted result words.
    always @(posedge clk)
    begin
        date_t want;
        date_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_dates.push_back(stamp_to_date(epoch_seconds));
            end
            if (out_valid && !out_stall)
            begin
                if (pending_dates.size() == 0)
                begin
                    date_mismatches++;
                    if (date_mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                 $realtime, year, month, day, hour, minute, second, weekday);
                    end
                end
                else
                begin
                    want = pending_dates.pop_front();
                    got  = '{want.stamp, year, month, day, hour, minute, second, weekday};
                    if (got.year !== want.year || got.month !== want.month
                        || got.mday !== want.mday || got.hour !== want.hour
                        || got.minute !== want.minute || got.second !== want.second
                        || got.weekday !== want.weekday)
                    begin
                        date_mismatches++;
                        if (date_mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: stamp %h expected %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     $realtime, want.stamp, want.year, want.month, want.mday,
                                     want.hour, want.minute, want.second, want.weekday);
                            $display("%0t: stamp %h actual   %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     $realtime, want.stamp, got.year, got.month, got.mday,
                                     got.hour, got.minute, got.second, got.weekday);
                        end
                    end
                end
            end
            dates_awaited = pending_dates.size();
        end
    end

endmodule

### tb/unix_seconds_to_date_unit_tb.sv
// ----------------------------------------------------------------------------
// Seconds-to-date converter testbench
// Feeds directed boundary stamps and then random stamps, with random gaps on
// the input side and random stalls on the result side. A checker beside the
// converter predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module unix_seconds_to_date_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import usd_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 2000;

    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    in_valid      = 1'b0;
    logic    in_stall;
    stamp_t  epoch_seconds = '0;
    logic    out_valid;
    logic    out_stall     = 1'b0;
    year_t   year;
    month_t  month;
    mday_t   day;
    hour_t   hour;
    minsec_t minute;
    minsec_t second;
    wday_t   weekday;
    int      date_mismatches;
    int      dates_awaited;
    int      quiet_cycles  = 0;

    // Boundary stamps: time-of-day edges, year and leap-day edges, the 2100
    // non-leap century, bit patterns, the last valid stamp and the marker.
    stamp_t directed_stamps[25] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000,
        32'd94694399, 32'd94694400, 32'd951782400, 32'd951868800,
        32'd4107542399, 32'd4107542400,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'hFFFF_FFFD, 32'hFFFF_FFFE, INVALID_STAMP
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    unix_seconds_to_date_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .epoch_seconds (epoch_seconds),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    unix_seconds_to_date_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .epoch_seconds   (epoch_seconds),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .year            (year),
        .month           (month),
        .day             (day),
        .hour            (hour),
        .minute          (minute),
        .second          (second),
        .weekday         (weekday),
        .date_mismatches (date_mismatches),
        .dates_awaited   (dates_awaited)
    );

    // Idle length: mostly from the shortest range, sometimes the middle one, rarely the long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 95)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    // Random stamp: plain random, whole days with edge offsets, near the
    // marker, the first days, and the dates around the 2100 leap gap.
    function automatic stamp_t random_stamp();
        logic [63:0] wide;
        int unsigned offset;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                return $urandom();
            end
            4, 5:
            begin
                case ($urandom_range(0, 2))
                    0:       offset = 0;
                    1:       offset = 86399;
                    default: offset = $urandom_range(0, 86399);
                endcase
                wide = 64'($urandom_range(0, 49710)) * 64'd86400 + 64'(offset);
                return wide[31:0];
            end
            6:
            begin
                return INVALID_STAMP - $urandom_range(0, 3);
            end
            7:
            begin
                return $urandom_range(0, 200000);
            end
            default:
            begin
                wide = 64'($urandom_range(47400, 47700)) * 64'd86400
                       + 64'($urandom_range(0, 86399));
                return wide[31:0];
            end
        endcase
    endfunction

    // Present one word and hold it until the converter takes it.
    task automatic send_stamp(stamp_t stamp);
        in_valid      <= 1'b1;
        epoch_seconds <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Drop valid and hold off until every expected result has come back.
    // A clock edge passes first so the checker has counted the last word sent.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (dates_awaited == 0);
        @(posedge clk);
    endtask

    // Result side stalls: free runs, some long, then a random stall.
    initial
    begin
        int free_len;
        int stall_len;
        forever
        begin
            free_len = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 6);
            repeat (free_len) @(posedge clk);
            stall_len = idle_len();
            out_stall <= 1'b1;
            repeat (stall_len) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int  gap;
        bit  calm;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words back to back, then drain.
        foreach (directed_stamps[i])
        begin
            send_stamp(directed_stamps[i]);
        end
        hold_until_drained();

        // Random words with gaps; some stretches run without gaps.
        calm = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 128 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            send_stamp(random_stamp());
            if (n == RANDOM_WORDS / 2)
            begin
                hold_until_drained();
            end
            else
            begin
                gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (dates_awaited == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (date_mismatches == 0 && dates_awaited == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
